[rtl/zswd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zswd_pkg
// Types, codes and character tables of the encoded text word decoder.
// ----------------------------------------------------------------------------
package zswd_pkg;

    localparam int VERSION_W = 4;
    localparam int WORD_W    = 16;
    localparam int ZCHAR_W   = 5;
    localparam int VALUE_W   = 10;
    localparam int ROW_W     = 2;
    localparam int BUF_DEPTH = 5;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int MAX_RES   = 4;

    localparam logic [VERSION_W-1:0] STORY_VERSION_RESET = 4'd3;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_ABBREV  = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ABBR   = 2'd1,
        PH_ESC_HI = 2'd2,
        PH_ESC_LO = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

    // Punctuation row; idx is 0..25
    function automatic logic [7:0] row2_char(input logic [ZCHAR_W-1:0] idx,
                                             input logic is_v1);
        logic [7:0] ch;
        ch = 8'h20;
        if (is_v1) begin
            case (idx)
                5'd0:  ch = 8'h20;
                5'd11: ch = 8'h2e;
                5'd12: ch = 8'h2c;
                5'd13: ch = 8'h21;
                5'd14: ch = 8'h3f;
                5'd15: ch = 8'h5f;
                5'd16: ch = 8'h23;
                5'd17: ch = 8'h27;
                5'd18: ch = 8'h22;
                5'd19: ch = 8'h2f;
                5'd20: ch = 8'h5c;
                5'd21: ch = 8'h3c;
                5'd22: ch = 8'h2d;
                5'd23: ch = 8'h3a;
                5'd24: ch = 8'h28;
                5'd25: ch = 8'h29;
                default: ch = 8'h30 + {3'd0, idx} - 8'd1;
            endcase
        end else begin
            case (idx)
                5'd0:  ch = 8'h20;
                5'd1:  ch = 8'h5e;
                5'd12: ch = 8'h2e;
                5'd13: ch = 8'h2c;
                5'd14: ch = 8'h21;
                5'd15: ch = 8'h3f;
                5'd16: ch = 8'h5f;
                5'd17: ch = 8'h23;
                5'd18: ch = 8'h27;
                5'd19: ch = 8'h22;
                5'd20: ch = 8'h2f;
                5'd21: ch = 8'h5c;
                5'd22: ch = 8'h2d;
                5'd23: ch = 8'h3a;
                5'd24: ch = 8'h28;
                5'd25: ch = 8'h29;
                default: ch = 8'h30 + {3'd0, idx} - 8'd2;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [VALUE_W-1:0] letter(input logic [ROW_W-1:0] row,
                                                  input logic [ZCHAR_W-1:0] idx,
                                                  input logic is_v1);
        logic [VALUE_W-1:0] res;
        case (row)
            2'd0:    res = VALUE_W'(8'h61) + VALUE_W'(idx);
            2'd1:    res = VALUE_W'(8'h41) + VALUE_W'(idx);
            default: res = VALUE_W'(row2_char(idx, is_v1));
        endcase
        return res;
    endfunction

endpackage

[rtl/zstring_word_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstring_word_decoder_unit
// Decodes one 16-bit encoded text word per transaction into characters,
// newlines, abbreviation references and an end-of-string marker.
// ----------------------------------------------------------------------------
// A word is decoded in the cycle it is accepted; its zero to four results go
// into a five-entry result buffer and leave one per cycle while i_out_ready
// is high, the last one flagged by o_last_of_word. The single result port sets
// the rate, as a word's results leave it one at a time. A new word is taken
// whenever at most one result is still buffered, so the input does not wait
// on a stalled output for its final result. Main and abbreviation strings
// keep separate shift and escape state; story_version may only be written
// while the block is idle.
module zstring_word_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [zswd_pkg::VERSION_W-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [zswd_pkg::WORD_W-1:0]   i_text_word,
    input  logic                          i_in_abbreviation,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [zswd_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_last_of_word
);
    import zswd_pkg::*;

    logic [VERSION_W-1:0] r_version;
    logic [ROW_W-1:0]     r_shift_now    [2];
    logic [ROW_W-1:0]     r_shift_locked [2];
    t_phase               r_escape_phase [2];
    logic [ZCHAR_W-1:0]   r_prev_zchar   [2];

    t_result              r_buf [BUF_DEPTH];
    logic [CNT_W-1:0]     r_cnt;

    logic                 in_acc;
    logic                 out_acc;
    logic                 is_v1, ge2, ge3;

    // decode results
    t_result              d_res [MAX_RES];
    logic [2:0]           d_n;
    logic [ROW_W-1:0]     d_sn, d_sl;
    t_phase               d_ph;
    logic [ZCHAR_W-1:0]   d_pc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt <= CNT_W'(1));
    assign o_out_valid = (r_cnt != '0);
    assign o_kind      = r_buf[0].kind;
    assign o_value     = r_buf[0].value;
    assign o_last_of_word = r_buf[0].last;

    assign is_v1 = (r_version <= 4'd1);
    assign ge2   = (r_version >= 4'd2);
    assign ge3   = (r_version >= 4'd3);

    always_comb begin
        logic               k;
        logic [ZCHAR_W-1:0] c;
        logic [ROW_W-1:0]   row;
        logic [2:0]         sum;
        logic               rs;
        k    = i_in_abbreviation;
        d_sn = r_shift_now[k];
        d_sl = r_shift_locked[k];
        d_ph = r_escape_phase[k];
        d_pc = r_prev_zchar[k];
        d_n  = '0;
        c    = '0;
        row  = '0;
        sum  = '0;
        rs   = 1'b0;
        for (int i = 0; i < MAX_RES; i++) begin
            d_res[i] = '{kind: KIND_CHAR, value: '0, last: 1'b0};
        end
        for (int i = 0; i < 3; i++) begin
            c   = i_text_word[(WORD_W-2)-ZCHAR_W*i -: ZCHAR_W];
            row = (d_sn == 2'd3) ? 2'd2 : d_sn;
            case (d_ph)
                PH_NORMAL: begin
                    rs = 1'b1;
                    if (row == 2'd2 && c == 5'd6) begin
                        d_ph = PH_ESC_HI;
                    end else if (is_v1 && c == 5'd1) begin
                        d_res[d_n[1:0]] = '{kind: KIND_NEWLINE, value: '0, last: 1'b0};
                        d_n = d_n + 3'd1;
                    end else if (ge2 && row == 2'd2 && c == 5'd7) begin
                        d_res[d_n[1:0]] = '{kind: KIND_NEWLINE, value: '0, last: 1'b0};
                        d_n = d_n + 3'd1;
                    end else if (c >= 5'd6) begin
                        d_res[d_n[1:0]] = '{kind: KIND_CHAR,
                                            value: letter(row, c - 5'd6, is_v1),
                                            last: 1'b0};
                        d_n = d_n + 3'd1;
                    end else if (c == 5'd0) begin
                        d_res[d_n[1:0]] = '{kind: KIND_CHAR, value: VALUE_W'(8'h20),
                                            last: 1'b0};
                        d_n = d_n + 3'd1;
                    end else if (ge2 && c == 5'd1) begin
                        d_ph = PH_ABBR;
                    end else if (ge3 && c <= 5'd3) begin
                        d_ph = PH_ABBR;
                    end else begin
                        sum = {1'b0, d_sl} + {2'd0, c[0]} + 3'd1;
                        if (sum >= 3'd3) begin
                            sum = sum - 3'd3;
                        end
                        d_sn = sum[ROW_W-1:0];
                        if (!ge3 && c >= 5'd4) begin
                            d_sl = sum[ROW_W-1:0];
                        end
                        rs = 1'b0;
                    end
                    if (rs) begin
                        d_sn = d_sl;
                    end
                end
                PH_ABBR: begin
                    d_res[d_n[1:0]] = '{kind: KIND_ABBREV, value: {d_pc - 5'd1, c},
                                        last: 1'b0};
                    d_n  = d_n + 3'd1;
                    d_ph = PH_NORMAL;
                end
                PH_ESC_HI: begin
                    d_ph = PH_ESC_LO;
                end
                default: begin
                    d_res[d_n[1:0]] = '{kind: KIND_CHAR, value: {d_pc, c}, last: 1'b0};
                    d_n  = d_n + 3'd1;
                    d_ph = PH_NORMAL;
                end
            endcase
            d_pc = c;
        end
        if (i_text_word[WORD_W-1]) begin
            d_res[d_n[1:0]] = '{kind: KIND_END, value: '0, last: 1'b0};
            d_n  = d_n + 3'd1;
            d_sn = '0;
            d_sl = '0;
            d_ph = PH_NORMAL;
            d_pc = '0;
        end
        if (d_n != 3'd0) begin
            d_res[d_n[1:0] - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= STORY_VERSION_RESET;
            for (int j = 0; j < 2; j++) begin
                r_shift_now[j]    <= '0;
                r_shift_locked[j] <= '0;
                r_escape_phase[j] <= PH_NORMAL;
                r_prev_zchar[j]   <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_version <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_shift_now[i_in_abbreviation]    <= d_sn;
                r_shift_locked[i_in_abbreviation] <= d_sl;
                r_escape_phase[i_in_abbreviation] <= d_ph;
                r_prev_zchar[i_in_abbreviation]   <= d_pc;
            end
        end
    end

    // result buffer: pop at the head, append behind what stays
    always_ff @(posedge i_clk) begin
        logic [CNT_W-1:0] keep;
        keep = r_cnt - CNT_W'(out_acc);
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= keep + (in_acc ? CNT_W'(d_n) : CNT_W'(0));
        end
        for (int j = 0; j < BUF_DEPTH; j++) begin
            if (CNT_W'(j) < keep) begin
                if (out_acc) begin
                    r_buf[j] <= r_buf[(j + 1) % BUF_DEPTH];
                end
            end else if (in_acc) begin
                if (keep == '0) begin
                    if (j < MAX_RES) begin
                        r_buf[j] <= d_res[j % MAX_RES];
                    end
                end else if (j >= 1) begin
                    r_buf[j] <= d_res[(j + MAX_RES - 1) % MAX_RES];
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BUF_DEPTH))
        else $error("result buffer overflow");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_text_word[WORD_W-1]) |=> o_out_valid)
        else $error("end of string produced no result");

    a_end_clears_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_text_word[WORD_W-1]) |=>
        (r_escape_phase[$past(i_in_abbreviation)] == PH_NORMAL &&
         r_shift_locked[$past(i_in_abbreviation)] == '0))
        else $error("context not cleared at end of string");

endmodule

[verif/tb_zstring_word_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zstring_word_decoder_unit
// Self-checking testbench for the encoded text word decoder. Directed words
// cover spaces, letters, shifts and locks, newlines, abbreviations, escapes,
// the two contexts and end of string under several versions. Random strings
// with embedded abbreviation strings and noise words follow, with random
// idling on both sides in all but one phase. A predictor queues the results
// of each accepted word; every output transaction is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_zstring_word_decoder_unit;
    import zswd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PCT    = 28;
    localparam int SETTLE      = 4;

    localparam logic [26*8-1:0] PUNCT_V1 = " 0123456789.,!?_#'\"/\\<-:()";
    localparam logic [26*8-1:0] PUNCT_V2 = " ^0123456789.,!?_#'\"/\\-:()";

    logic                 i_clk;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_wr_en       = 1'b0;
    logic [VERSION_W-1:0] i_cfg_wr_data     = '0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_ready;
    logic [WORD_W-1:0]    i_text_word       = '0;
    logic                 i_in_abbreviation = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready       = 1'b0;
    logic [1:0]           o_kind;
    logic [VALUE_W-1:0]   o_value;
    logic                 o_last_of_word;

    zstring_word_decoder_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_text_word       (i_text_word),
        .i_in_abbreviation (i_in_abbreviation),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_value           (o_value),
        .o_last_of_word    (o_last_of_word)
    );

    // Decoder state mirror, one entry per context
    logic [VERSION_W-1:0] story_ver;
    logic [ROW_W-1:0]     row_now  [2];
    logic [ROW_W-1:0]     row_lock [2];
    t_phase               esc_state[2];
    logic [ZCHAR_W-1:0]   last_zc  [2];

    t_result expected_results[$];
    t_result word_results[$];

    int  errors          = 0;
    int  words_sent      = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    int  idle_cycles     = 0;
    bit  gaps_on         = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic int eff_version();
        int v;
        v = story_ver;
        if (v < 1) v = 1;
        if (v > 8) v = 8;
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] glyph(input logic [ROW_W-1:0] row,
                                                 input int idx, input int ver);
        if (row == 2'd0) return VALUE_W'(8'h61 + idx);
        if (row == 2'd1) return VALUE_W'(8'h41 + idx);
        if (ver == 1) return VALUE_W'(PUNCT_V1[(25 - idx) * 8 +: 8]);
        return VALUE_W'(PUNCT_V2[(25 - idx) * 8 +: 8]);
    endfunction

    function automatic void add_result(input t_kind kind, input logic [VALUE_W-1:0] value);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        word_results.push_back(r);
    endfunction

    function automatic void predict_word(input logic [WORD_W-1:0] word, input logic ctx);
        int                 ver;
        int                 ns;
        int                 s;
        logic [ZCHAR_W-1:0] zc;
        logic [ROW_W-1:0]   row;
        logic               restore_row;
        t_result            r;
        ver = eff_version();
        word_results.delete();
        for (s = 2; s >= 0; s--) begin
            zc  = word[s * 5 +: 5];
            row = (row_now[ctx] > 2'd2) ? 2'd2 : row_now[ctx];
            case (esc_state[ctx])
                PH_NORMAL: begin
                    restore_row = 1'b1;
                    if (row == 2'd2 && zc == 5'd6) begin
                        esc_state[ctx] = PH_ESC_HI;
                    end else if (ver == 1 && zc == 5'd1) begin
                        add_result(KIND_NEWLINE, '0);
                    end else if (ver >= 2 && row == 2'd2 && zc == 5'd7) begin
                        add_result(KIND_NEWLINE, '0);
                    end else if (zc >= 5'd6) begin
                        add_result(KIND_CHAR, glyph(row, int'(zc) - 6, ver));
                    end else if (zc == 5'd0) begin
                        add_result(KIND_CHAR, VALUE_W'(8'h20));
                    end else if (ver >= 2 && zc == 5'd1) begin
                        esc_state[ctx] = PH_ABBR;
                    end else if (ver >= 3 && zc <= 5'd3) begin
                        esc_state[ctx] = PH_ABBR;
                    end else begin
                        ns = (int'(row_lock[ctx]) + int'(zc[0]) + 1) % 3;
                        row_now[ctx] = ROW_W'(ns);
                        if (ver <= 2 && zc >= 5'd4) row_lock[ctx] = ROW_W'(ns);
                        restore_row = 1'b0;
                    end
                    if (restore_row) row_now[ctx] = row_lock[ctx];
                end
                PH_ABBR: begin
                    add_result(KIND_ABBREV, {last_zc[ctx] - 5'd1, zc});
                    esc_state[ctx] = PH_NORMAL;
                end
                PH_ESC_HI: begin
                    esc_state[ctx] = PH_ESC_LO;
                end
                default: begin
                    add_result(KIND_CHAR, {last_zc[ctx], zc});
                    esc_state[ctx] = PH_NORMAL;
                end
            endcase
            last_zc[ctx] = zc;
        end
        if (word[WORD_W-1]) begin
            add_result(KIND_END, '0);
            row_now[ctx]   = '0;
            row_lock[ctx]  = '0;
            esc_state[ctx] = PH_NORMAL;
            last_zc[ctx]   = '0;
        end
        for (s = 0; s < word_results.size(); s++) begin
            r      = word_results[s];
            r.last = (s == word_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    task automatic check_result();
        t_result e;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %0d last %0d",
                                      o_kind, o_value, o_last_of_word));
        end else begin
            e = expected_results.pop_front();
            results_checked++;
            if (o_kind !== e.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", o_kind, e.kind));
            if (o_value !== e.value)
                report_mismatch($sformatf("value %0d, expected %0d", o_value, e.value));
            if (o_last_of_word !== e.last)
                report_mismatch($sformatf("last_of_word %0d, expected %0d",
                                          o_last_of_word, e.last));
        end
    endtask

    // Check output first, then predict the accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            story_ver = STORY_VERSION_RESET;
            for (int c = 0; c < 2; c++) begin
                row_now[c]   = '0;
                row_lock[c]  = '0;
                esc_state[c] = PH_NORMAL;
                last_zc[c]   = '0;
            end
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (i_cfg_wr_en) story_ver = i_cfg_wr_data;
            if (i_in_valid && o_in_ready) begin
                predict_word(i_text_word, i_in_abbreviation);
                words_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [WORD_W-1:0] zw(input logic fin, input logic [4:0] a,
                                             input logic [4:0] b, input logic [4:0] c);
        return {fin, a, b, c};
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word, input logic ctx);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_text_word       <= word;
        i_in_abbreviation <= ctx;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_version(input logic [VERSION_W-1:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [4:0] rand_zchar();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 5'($urandom_range(6, 31));
        if (p < 63) return 5'd0;
        if (p < 78) return 5'($urandom_range(4, 5));
        if (p < 88) return 5'($urandom_range(1, 3));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic send_string(input logic ctx, input int len);
        for (int i = 0; i < len; i++)
            send_word(zw(i == len - 1, rand_zchar(), rand_zchar(), rand_zchar()), ctx);
    endtask

    task automatic test_spaces_and_letters();
        send_word(16'h0000, 1'b0);
        send_word(zw(0, 6, 31, 15), 1'b0);
        send_word(16'h7fff, 1'b0);
    endtask

    task automatic test_shifts_and_newline();
        send_word(zw(0, 4, 6, 31), 1'b0);
        send_word(zw(0, 5, 8, 5), 1'b0);
        send_word(zw(0, 7, 5, 7), 1'b0);
        send_word(zw(0, 4, 4, 4), 1'b0);   // shifts only, no output
    endtask

    task automatic test_abbreviations();
        send_word(zw(0, 1, 0, 2), 1'b0);
        send_word(zw(0, 31, 3, 31), 1'b0);
    endtask

    task automatic test_escapes();
        send_word(zw(0, 5, 6, 3), 1'b0);
        send_word(zw(0, 28, 0, 0), 1'b0);
        send_word(zw(1, 5, 6, 31), 1'b0);  // escape cut off by end of string
    endtask

    task automatic test_contexts_and_end();
        send_word(zw(0, 5, 6, 1), 1'b1);
        send_word(zw(0, 6, 6, 6), 1'b0);
        send_word(zw(0, 2, 0, 0), 1'b1);
        send_word(zw(1, 0, 0, 1), 1'b1);   // abbreviation cut off by end of string
        send_word(16'h8000, 1'b0);
        send_word(16'hffff, 1'b0);
    endtask

    task automatic test_version1_rules();
        write_version(4'd1);
        send_word(zw(0, 1, 4, 8), 1'b0);
        send_word(zw(0, 5, 7, 5), 1'b0);
        send_word(zw(0, 8, 27, 4), 1'b0);
        send_word(zw(1, 0, 0, 0), 1'b0);
    endtask

    task automatic test_version2_rules();
        write_version(4'd2);
        send_word(zw(0, 1, 7, 4), 1'b0);
        send_word(zw(0, 2, 9, 0), 1'b0);
        send_word(zw(0, 5, 7, 3), 1'b0);
        send_word(zw(1, 7, 0, 0), 1'b0);
    endtask

    task automatic test_random_strings(input logic [VERSION_W-1:0] v, input int n,
                                       input bit gaps);
        int start;
        write_version(v);
        gaps_on = gaps;
        start   = words_sent;
        while (words_sent - start < n) begin
            if ($urandom_range(0, 99) < 15) begin
                send_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 99) < 25) send_string(1'b1, $urandom_range(1, 2));
                send_string(1'b0, $urandom_range(1, 5));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        logic [VERSION_W-1:0] phase_ver[12];
        phase_ver = '{4'd3, 4'd1, 4'd2, 4'd8, 4'd0, 4'd15, 4'd4, 4'd9, 4'd5, 4'd1, 4'd2, 4'd3};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_spaces_and_letters();
        test_shifts_and_newline();
        test_abbreviations();
        test_escapes();
        test_contexts_and_end();
        test_version1_rules();
        test_version2_rules();
        for (int p = 0; p < 12; p++)
            test_random_strings(phase_ver[p], 32, p != 3);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        $display("Decoded %0d words into %0d checked results", words_sent, results_checked);
        $display("story_version written %0d times, mismatches: %0d", cfg_writes, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
